@@ hw/rtl/service_bridge_irq_register_block_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the service bridge register block
// Immediate-cycle and next-cycle implication checks under synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SERVICE_BRIDGE_IRQ_REGISTER_BLOCK_ASSERT_SVH
`define SERVICE_BRIDGE_IRQ_REGISTER_BLOCK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SBIRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SBIRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sbirq_pkg.sv @@
// ----------------------------------------------------------------------------
// sbirq_pkg
// Types, register map constants and lookup functions for the bridge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbirq_pkg;

    // Register file geometry
    localparam int unsigned NREGS      = 28;
    localparam int unsigned MMIO_SHIFT = 10;

    // Register map (word offsets)
    localparam logic [4:0] REG_FIR     = 5'd0;
    localparam logic [4:0] REG_FIR_AND = 5'd1;
    localparam logic [4:0] REG_FIR_OR  = 5'd2;
    localparam logic [4:0] REG_ACT0    = 5'd6;
    localparam logic [4:0] REG_ACT1    = 5'd7;
    localparam logic [4:0] REG_BAR     = 5'd10;
    localparam logic [4:0] REG_FSPBAR  = 5'd11;
    localparam logic [4:0] REG_CR      = 5'd14;
    localparam logic [4:0] REG_SEMR    = 5'd15;
    localparam logic [4:0] REG_XV_FSP  = 5'd16;
    localparam logic [4:0] REG_SCR     = 5'd18;
    localparam logic [4:0] REG_CCR     = 5'd19;
    localparam logic [4:0] REG_DMA     = 5'd20;
    localparam logic [4:0] REG_STAT    = 5'd21;
    localparam logic [4:0] REG_XV_OCC  = 5'd22;
    localparam logic [4:0] REG_XV_FSI  = 5'd23;
    localparam logic [4:0] REG_XV_LPC  = 5'd24;
    localparam logic [4:0] REG_XV_LOC  = 5'd25;
    localparam logic [4:0] REG_XV_EXT  = 5'd26;
    localparam logic [4:0] REG_IRSN    = 5'd27;

    // Status memory entries (control and interrupt status registers)
    localparam logic STAT_IDX_CR   = 1'b0;
    localparam logic STAT_IDX_STAT = 1'b1;

    // Field masks
    localparam logic [63:0] BAR_KEEP     = 64'h0003_ffff_fff0_0001;
    localparam logic [63:0] BAR_EN       = 64'h0000_0000_0000_0001;
    localparam logic [63:0] FSPBAR_KEEP  = 64'h0003_ffff_0000_0000;
    localparam logic [63:0] XV_KEEP      = 64'h00ff_ffff_e000_0000;
    localparam logic [63:0] XV_PRIO_MASK = 64'h0000_00ff_0000_0000;
    localparam logic [63:0] XV_PENDING   = 64'h0000_0000_0100_0000;
    localparam logic [63:0] CR_PSI_IRQ   = 64'h0000_8000_0000_0000;
    localparam logic [63:0] CR_FSP_IRQ   = 64'h0000_4000_0000_0000;
    localparam logic [63:0] IRSN_KEEP    = 64'hffff_e00f_0000_0000;
    localparam logic [7:0]  PRIO_MASKED  = 8'hff;
    localparam logic [2:0]  NUM_SOURCES  = 3'd6;
    localparam logic [2:0]  LAST_LINE    = 3'd6;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_EVENT = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNIMP   = 2'd1,
        ST_REFUSED = 2'd2,
        ST_BAD_SRC = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RAISE = 2'd1,
        ACT_LOWER = 2'd2
    } t_act;

    // What the update stage has to do with a request
    typedef enum logic [3:0] {
        K_NONE,
        K_RD_MAIN,
        K_RD_STAT,
        K_RD_UNIMP,
        K_WR_MAIN,
        K_WR_OR,
        K_WR_AND,
        K_WR_STAT,
        K_SET_STAT,
        K_CLR_STAT,
        K_IRSN,
        K_VEC,
        K_REFUSE,
        K_WR_UNIMP,
        K_EVENT,
        K_BAD_LINE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  main_addr;
        logic        stat_addr;
        logic [63:0] data;
        logic [2:0]  line;
        logic        level;
    } t_req;

    typedef struct packed {
        logic        main_we;
        logic [4:0]  main_addr;
        logic [63:0] main_data;
        logic        stat_we;
        logic        stat_addr;
        logic [63:0] stat_data;
    } t_wr;

    typedef struct packed {
        logic [63:0] read_data;
        t_status     status;
        t_act        line_action;
        logic [2:0]  line_source;
        logic        route_valid;
        logic [2:0]  route_source;
        logic [13:0] route_server;
        logic [7:0]  route_priority;
        logic        offset_valid;
        logic [18:0] source_offset;
    } t_result;

    // Reset contents of the main register memory
    function automatic logic [63:0] main_reset_value(input logic [4:0] addr);
        logic [63:0] val;
        val = '0;
        unique case (addr)
            REG_BAR:    val = BAR_EN;
            REG_XV_FSP: val = XV_PRIO_MASK;
            REG_XV_OCC: val = XV_PRIO_MASK | {32'd0, 3'd1, 29'd0};
            REG_XV_FSI: val = XV_PRIO_MASK | {32'd0, 3'd2, 29'd0};
            REG_XV_LPC: val = XV_PRIO_MASK | {32'd0, 3'd3, 29'd0};
            REG_XV_LOC: val = XV_PRIO_MASK | {32'd0, 3'd4, 29'd0};
            REG_XV_EXT: val = XV_PRIO_MASK | {32'd0, 3'd5, 29'd0};
            default:    val = '0;
        endcase
        return val;
    endfunction

    // Vector register that serves an interrupt line
    function automatic logic [4:0] vec_reg_of_line(input logic [2:0] line);
        logic [4:0] reg_idx;
        reg_idx = REG_XV_FSP;
        unique case (line)
            3'd0, 3'd1: reg_idx = REG_XV_FSP;
            3'd2:       reg_idx = REG_XV_OCC;
            3'd3:       reg_idx = REG_XV_FSI;
            3'd4:       reg_idx = REG_XV_LPC;
            3'd5:       reg_idx = REG_XV_LOC;
            3'd6:       reg_idx = REG_XV_EXT;
            default:    reg_idx = REG_XV_FSP;
        endcase
        return reg_idx;
    endfunction

    // Status bit that an interrupt line drives
    function automatic logic [63:0] stat_bit_of_line(input logic [2:0] line);
        logic [63:0] bit_mask;
        bit_mask = '0;
        unique case (line)
            3'd0:    bit_mask = CR_PSI_IRQ;
            3'd1:    bit_mask = CR_FSP_IRQ;
            3'd2:    bit_mask = 64'h0000_0010_0000_0000;
            3'd3:    bit_mask = 64'h0000_0008_0000_0000;
            3'd4:    bit_mask = 64'h0000_0004_0000_0000;
            3'd5:    bit_mask = 64'h0000_0002_0000_0000;
            3'd6:    bit_mask = 64'h0000_0001_0000_0000;
            default: bit_mask = '0;
        endcase
        return bit_mask;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sbirq_decode.sv @@
// ----------------------------------------------------------------------------
// sbirq_decode
// Turns an incoming request into memory read addresses and an update kind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbirq_decode (
    input  wire logic [1:0]     i_operation,
    input  wire logic [4:0]     i_word_index,
    input  wire logic           i_via_mmio,
    input  wire logic [63:0]    i_write_data,
    input  wire logic [2:0]     i_line_number,
    input  wire logic           i_line_level,
    output sbirq_pkg::t_req     o_req
);
    import sbirq_pkg::*;

    logic [5:0] w_off;
    logic       w_in_file;
    logic [4:0] w_addr;
    logic       w_is_vec;
    logic       w_readable;

    // Form the register offset; the memory-mapped path is shifted up
    assign w_off     = {1'b0, i_word_index} + (i_via_mmio ? 6'(MMIO_SHIFT) : 6'd0);
    assign w_in_file = w_off < 6'(NREGS);
    assign w_addr    = w_off[4:0];

    assign w_is_vec = (w_addr == REG_XV_FSP) || (w_addr == REG_XV_OCC) ||
                      (w_addr == REG_XV_FSI) || (w_addr == REG_XV_LPC) ||
                      (w_addr == REG_XV_LOC) || (w_addr == REG_XV_EXT);

    assign w_readable = w_is_vec || (w_addr == REG_FIR) || (w_addr == REG_ACT0) ||
                        (w_addr == REG_ACT1) || (w_addr == REG_BAR) ||
                        (w_addr == REG_FSPBAR) || (w_addr == REG_CR) ||
                        (w_addr == REG_SEMR) || (w_addr == REG_DMA) ||
                        (w_addr == REG_STAT) || (w_addr == REG_IRSN);

    // Classify the request and pick the entries to read
    always_comb begin
        o_req           = '0;
        o_req.kind      = K_NONE;
        o_req.main_addr = REG_FIR;
        o_req.stat_addr = STAT_IDX_CR;
        o_req.data      = i_write_data;
        o_req.line      = i_line_number;
        o_req.level     = i_line_level;
        unique case (t_op'(i_operation))
            OP_READ: begin
                if (w_in_file && w_readable) begin
                    if (w_addr == REG_CR) begin
                        o_req.kind      = K_RD_STAT;
                        o_req.stat_addr = STAT_IDX_CR;
                    end else if (w_addr == REG_STAT) begin
                        o_req.kind      = K_RD_STAT;
                        o_req.stat_addr = STAT_IDX_STAT;
                    end else begin
                        o_req.kind      = K_RD_MAIN;
                        o_req.main_addr = w_addr;
                    end
                end else begin
                    o_req.kind = K_RD_UNIMP;
                end
            end
            OP_WRITE: begin
                if (!w_in_file) begin
                    o_req.kind = K_WR_UNIMP;
                end else begin
                    o_req.main_addr = w_addr;
                    unique case (w_addr)
                        REG_FIR, REG_ACT0, REG_ACT1, REG_SEMR, REG_DMA: begin
                            o_req.kind = K_WR_MAIN;
                        end
                        REG_FIR_OR: begin
                            o_req.kind      = K_WR_OR;
                            o_req.main_addr = REG_FIR;
                        end
                        REG_FIR_AND: begin
                            o_req.kind      = K_WR_AND;
                            o_req.main_addr = REG_FIR;
                        end
                        REG_BAR: begin
                            o_req.kind = i_via_mmio ? K_REFUSE : K_WR_MAIN;
                            o_req.data = i_write_data & BAR_KEEP;
                        end
                        REG_FSPBAR: begin
                            o_req.kind = K_WR_MAIN;
                            o_req.data = i_write_data & FSPBAR_KEEP;
                        end
                        REG_CR:   o_req.kind = K_WR_STAT;
                        REG_SCR:  o_req.kind = K_SET_STAT;
                        REG_CCR:  o_req.kind = K_CLR_STAT;
                        REG_STAT: o_req.kind = K_REFUSE;
                        REG_IRSN: begin
                            o_req.kind = K_IRSN;
                            o_req.data = i_write_data & IRSN_KEEP;
                        end
                        REG_XV_FSP, REG_XV_OCC, REG_XV_FSI, REG_XV_LPC, REG_XV_LOC,
                        REG_XV_EXT: begin
                            o_req.kind = K_VEC;
                            o_req.data = i_write_data & XV_KEEP;
                        end
                        default: o_req.kind = K_WR_UNIMP;
                    endcase
                end
            end
            OP_EVENT: begin
                if (i_line_number > LAST_LINE) begin
                    o_req.kind = K_BAD_LINE;
                end else begin
                    o_req.kind      = K_EVENT;
                    o_req.main_addr = vec_reg_of_line(i_line_number);
                    o_req.stat_addr = (i_line_number < 3'd2) ? STAT_IDX_CR : STAT_IDX_STAT;
                end
            end
            OP_NONE: o_req.kind = K_NONE;
            default: o_req.kind = K_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/sbirq_store.sv @@
// ----------------------------------------------------------------------------
// sbirq_store
// Main and status register memories with valid bits and write forwarding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbirq_store (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_rd_en,
    input  wire logic [4:0]     i_rd_main_addr,
    input  wire logic           i_rd_stat_addr,
    input  wire sbirq_pkg::t_wr i_wr,
    output logic [63:0]         o_main_q,
    output logic [63:0]         o_stat_q
);
    import sbirq_pkg::*;

    logic [63:0] mem_main [NREGS];
    logic [63:0] mem_stat [2];

    logic [NREGS-1:0] r_main_vld;
    logic [1:0]       r_stat_vld;

    logic [63:0] r_main_q;
    logic [63:0] r_stat_q;
    logic [4:0]  r_main_ra;
    logic        r_main_fwd;
    logic        r_main_rst;
    logic [63:0] r_main_fwd_d;
    logic        r_stat_fwd;
    logic        r_stat_rst;
    logic [63:0] r_stat_fwd_d;

    // Write port and registered read port of the main memory
    always_ff @(posedge i_clk) begin
        if (i_wr.main_we) begin
            mem_main[i_wr.main_addr] <= i_wr.main_data;
        end
        if (i_rd_en) begin
            r_main_q <= mem_main[i_rd_main_addr];
        end
    end

    // Write port and registered read port of the status memory
    always_ff @(posedge i_clk) begin
        if (i_wr.stat_we) begin
            mem_stat[i_wr.stat_addr] <= i_wr.stat_data;
        end
        if (i_rd_en) begin
            r_stat_q <= mem_stat[i_rd_stat_addr];
        end
    end

    // Mark entries once written; unwritten ones read as their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= '0;
            r_stat_vld <= '0;
        end else begin
            if (i_wr.main_we) begin
                r_main_vld[i_wr.main_addr] <= 1'b1;
            end
            if (i_wr.stat_we) begin
                r_stat_vld[i_wr.stat_addr] <= 1'b1;
            end
        end
    end

    // Capture read source: forwarded write, reset value or memory
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_main_ra    <= i_rd_main_addr;
            r_main_fwd   <= i_wr.main_we && (i_wr.main_addr == i_rd_main_addr);
            r_main_fwd_d <= i_wr.main_data;
            r_main_rst   <= !r_main_vld[i_rd_main_addr];
            r_stat_fwd   <= i_wr.stat_we && (i_wr.stat_addr == i_rd_stat_addr);
            r_stat_fwd_d <= i_wr.stat_data;
            r_stat_rst   <= !r_stat_vld[i_rd_stat_addr];
        end
    end

    assign o_main_q = r_main_fwd ? r_main_fwd_d :
                      r_main_rst ? main_reset_value(r_main_ra) : r_main_q;
    assign o_stat_q = r_stat_fwd ? r_stat_fwd_d :
                      r_stat_rst ? 64'd0 : r_stat_q;

endmodule

`default_nettype wire

@@ hw/rtl/sbirq_update.sv @@
// ----------------------------------------------------------------------------
// sbirq_update
// Modify step: builds write-back values and the result from read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbirq_update (
    input  wire sbirq_pkg::t_req    i_req,
    input  wire logic [63:0]        i_main_q,
    input  wire logic [63:0]        i_stat_q,
    output sbirq_pkg::t_wr          o_wr,
    output sbirq_pkg::t_result      o_res
);
    import sbirq_pkg::*;

    logic [63:0] w_vec_new;
    logic [2:0]  w_vec_src;
    logic [63:0] w_bit;
    logic [63:0] w_stat_new;
    logic [2:0]  w_evt_src;
    logic        w_evt_masked;
    logic        w_other_set;

    // Vector write keeps the pending bit and takes the routing fields
    assign w_vec_new = (i_main_q & XV_PENDING) | i_req.data;
    assign w_vec_src = w_vec_new[31:29];

    // Line event: new status word and the vector it routes through
    assign w_bit        = stat_bit_of_line(i_req.line);
    assign w_stat_new   = i_req.level ? (i_stat_q | w_bit) : (i_stat_q & ~w_bit);
    assign w_evt_src    = i_main_q[31:29];
    assign w_evt_masked = i_main_q[39:32] == PRIO_MASKED;
    assign w_other_set  = (i_req.stat_addr == STAT_IDX_CR) &&
                          ((w_stat_new & (CR_PSI_IRQ | CR_FSP_IRQ)) != 64'd0);

    always_comb begin
        o_wr           = '0;
        o_wr.main_addr = i_req.main_addr;
        o_wr.stat_addr = i_req.stat_addr;
        o_res          = '0;
        o_res.status      = ST_OK;
        o_res.line_action = ACT_NONE;
        unique case (i_req.kind)
            K_NONE:     ;
            K_RD_MAIN:  o_res.read_data = i_main_q;
            K_RD_STAT:  o_res.read_data = i_stat_q;
            K_RD_UNIMP: begin
                o_res.read_data = '1;
                o_res.status    = ST_UNIMP;
            end
            K_WR_MAIN: begin
                o_wr.main_we   = 1'b1;
                o_wr.main_data = i_req.data;
            end
            K_WR_OR: begin
                o_wr.main_we   = 1'b1;
                o_wr.main_data = i_main_q | i_req.data;
            end
            K_WR_AND: begin
                o_wr.main_we   = 1'b1;
                o_wr.main_data = i_main_q & i_req.data;
            end
            K_WR_STAT: begin
                o_wr.stat_we   = 1'b1;
                o_wr.stat_data = i_req.data;
            end
            K_SET_STAT: begin
                o_wr.stat_we   = 1'b1;
                o_wr.stat_data = i_stat_q | i_req.data;
            end
            K_CLR_STAT: begin
                o_wr.stat_we   = 1'b1;
                o_wr.stat_data = i_stat_q & ~i_req.data;
            end
            K_IRSN: begin
                o_wr.main_we        = 1'b1;
                o_wr.main_data      = i_req.data;
                o_res.offset_valid  = 1'b1;
                o_res.source_offset = i_req.data[63:45];
            end
            K_VEC: begin
                o_wr.main_we   = 1'b1;
                o_wr.main_data = w_vec_new;
                if (w_vec_src >= NUM_SOURCES) begin
                    // Unroutable source: store as written, no route update
                    o_res.status = ST_BAD_SRC;
                end else begin
                    if (w_vec_new[39:32] == PRIO_MASKED) begin
                        o_wr.main_data = w_vec_new & ~XV_PENDING;
                    end
                    o_res.route_valid    = 1'b1;
                    o_res.route_source   = w_vec_src;
                    o_res.route_server   = w_vec_new[55:42];
                    o_res.route_priority = w_vec_new[39:32];
                end
            end
            K_REFUSE:   o_res.status = ST_REFUSED;
            K_WR_UNIMP: o_res.status = ST_UNIMP;
            K_EVENT: begin
                o_wr.stat_we   = 1'b1;
                o_wr.stat_data = w_stat_new;
                o_wr.main_we   = 1'b1;
                // Hold the shared line high while the other muxed source is set
                if (i_req.level) begin
                    o_res.line_action = ACT_RAISE;
                    o_res.line_source = w_evt_src;
                end else if (!w_other_set) begin
                    o_res.line_action = ACT_LOWER;
                    o_res.line_source = w_evt_src;
                end
                if ((i_req.level || w_other_set) && !w_evt_masked) begin
                    o_wr.main_data = i_main_q | XV_PENDING;
                end else begin
                    o_wr.main_data = i_main_q & ~XV_PENDING;
                end
            end
            K_BAD_LINE: o_res.status = ST_BAD_SRC;
            default:    ;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/service_bridge_irq_register_block.sv @@
// ----------------------------------------------------------------------------
// service_bridge_irq_register_block
// Service bridge register block with interrupt-line handling.
//
// Input channel (i_valid / o_stall) carries one request per cycle while o_stall
// is low: a register read, a register write or an interrupt line event. Output
// channel (o_valid / i_stall) returns exactly one result per request, in order.
//
// Pipeline: on accept the memories are read into registers and the request is
// held in stage one; the read-modify-write pass on that data feeds the output
// register. Throughput is one request per cycle when not stalled, set by one
// read-modify-write pass per cycle, with writes forwarded to a same-entry read.
//
// Reset clears the entry valid bits and the pipeline; unwritten entries read
// as their reset value, so a request may be accepted right after reset.
// When the receiver stalls, the held result stays on the output and one more
// request completes into the modify stage; then o_stall rises until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "service_bridge_irq_register_block_assert.svh"

module service_bridge_irq_register_block (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [1:0]     i_operation,
    input  wire logic [4:0]     i_word_index,
    input  wire logic           i_via_mmio,
    input  wire logic [63:0]    i_write_data,
    input  wire logic [2:0]     i_line_number,
    input  wire logic           i_line_level,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [63:0]         o_read_data,
    output logic [1:0]          o_status,
    output logic [1:0]          o_line_action,
    output logic [2:0]          o_line_source,
    output logic                o_route_valid,
    output logic [2:0]          o_route_source,
    output logic [13:0]         o_route_server,
    output logic [7:0]          o_route_priority,
    output logic                o_offset_valid,
    output logic [18:0]         o_source_offset
);
    import sbirq_pkg::*;

    t_req        w_dec;
    t_req        r_req;
    logic        r_s1_vld;
    logic        r_out_vld;
    t_result     r_out;
    t_result     w_res;
    t_wr         w_wr;
    t_wr         w_wr_g;
    logic [63:0] w_main_q;
    logic [63:0] w_stat_q;
    logic        w_accept;
    logic        w_s1_adv;
    logic        w_s1_fire;

    // Handshake: modify stage moves on whenever the output register frees up
    assign w_s1_adv  = !r_out_vld || !i_stall;
    assign w_s1_fire = r_s1_vld && w_s1_adv;
    assign o_stall   = r_s1_vld && !w_s1_adv;
    assign w_accept  = i_valid && !o_stall;

    // Decode the incoming request
    sbirq_decode u_decode (
        .i_operation  (i_operation),
        .i_word_index (i_word_index),
        .i_via_mmio   (i_via_mmio),
        .i_write_data (i_write_data),
        .i_line_number(i_line_number),
        .i_line_level (i_line_level),
        .o_req        (w_dec)
    );

    // Register memories, read on accept, written when the modify stage fires
    sbirq_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (w_accept),
        .i_rd_main_addr(w_dec.main_addr),
        .i_rd_stat_addr(w_dec.stat_addr),
        .i_wr          (w_wr_g),
        .o_main_q      (w_main_q),
        .o_stat_q      (w_stat_q)
    );

    // Modify step on the request held in stage one
    sbirq_update u_update (
        .i_req  (r_req),
        .i_main_q(w_main_q),
        .i_stat_q(w_stat_q),
        .o_wr   (w_wr),
        .o_res  (w_res)
    );

    // Gate write-back so a held request writes exactly once
    always_comb begin
        w_wr_g         = w_wr;
        w_wr_g.main_we = w_wr.main_we && w_s1_fire;
        w_wr_g.stat_we = w_wr.stat_we && w_s1_fire;
    end

    // Stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Stage one request payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= w_dec;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_read_data      = r_out.read_data;
    assign o_status         = r_out.status;
    assign o_line_action    = r_out.line_action;
    assign o_line_source    = r_out.line_source;
    assign o_route_valid    = r_out.route_valid;
    assign o_route_source   = r_out.route_source;
    assign o_route_server   = r_out.route_server;
    assign o_route_priority = r_out.route_priority;
    assign o_offset_valid   = r_out.offset_valid;
    assign o_source_offset  = r_out.source_offset;

    // A route update only comes from a clean vector write
    `SBIRQ_ASSERT_NOW(a_route_clean, i_clk, i_rst_n, o_valid && o_route_valid,
        o_status == ST_OK && o_line_action == ACT_NONE && !o_offset_valid,
        "route update alongside another result")

    // A line action never carries read data or an error
    `SBIRQ_ASSERT_NOW(a_action_clean, i_clk, i_rst_n, o_valid && o_line_action != ACT_NONE,
        o_status == ST_OK && o_read_data == 64'd0,
        "line action with read data or error status")

    // A request leaving the modify stage lands in the output register
    `SBIRQ_ASSERT_NEXT(a_fire_lands, i_clk, i_rst_n, w_s1_fire, r_out_vld,
        "fired request lost before output")

endmodule

`default_nettype wire

@@ tb/sbirq_checker.sv @@
// ----------------------------------------------------------------------------
// sbirq_checker
// Watches both channels of the service bridge register block. Keeps its own
// copy of the register file, works out the result of every accepted request
// and compares each returned result against the oldest one still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbirq_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        i_req_valid,
    input  wire logic        i_req_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [4:0]  i_word_index,
    input  wire logic        i_via_mmio,
    input  wire logic [63:0] i_write_data,
    input  wire logic [2:0]  i_line_number,
    input  wire logic        i_line_level,
    // result side
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_stall,
    input  wire logic [63:0] i_read_data,
    input  wire logic [1:0]  i_status,
    input  wire logic [1:0]  i_line_action,
    input  wire logic [2:0]  i_line_source,
    input  wire logic        i_route_valid,
    input  wire logic [2:0]  i_route_source,
    input  wire logic [13:0] i_route_server,
    input  wire logic [7:0]  i_route_priority,
    input  wire logic        i_offset_valid,
    input  wire logic [18:0] i_source_offset,
    output int               o_error_count,
    output int               o_outstanding
);

    import sbirq_pkg::*;

    // Writable fields and status bits of the register map
    localparam logic [63:0] BAR_WRITABLE    = 64'h0003_ffff_fff0_0001;
    localparam logic [63:0] FSPBAR_WRITABLE = 64'h0003_ffff_0000_0000;
    localparam logic [63:0] VEC_FIELDS      = 64'h00ff_ffff_e000_0000;
    localparam logic [63:0] VEC_PRIO        = 64'h0000_00ff_0000_0000;
    localparam logic [63:0] VEC_PENDING     = 64'h0000_0000_0100_0000;
    localparam logic [63:0] IRSN_WRITABLE   = 64'hffff_e00f_0000_0000;
    localparam logic [63:0] IRQ_PSI         = 64'h0000_8000_0000_0000;
    localparam logic [63:0] IRQ_FSP         = 64'h0000_4000_0000_0000;
    localparam logic [63:0] IRQ_OCC         = 64'h0000_0010_0000_0000;
    localparam logic [63:0] IRQ_FSI         = 64'h0000_0008_0000_0000;
    localparam logic [63:0] IRQ_LPC         = 64'h0000_0004_0000_0000;
    localparam logic [63:0] IRQ_LOCERR      = 64'h0000_0002_0000_0000;
    localparam logic [63:0] IRQ_EXT         = 64'h0000_0001_0000_0000;

    logic [63:0] bridge_regs [0:NREGS-1];
    t_result     expected_results [$];

    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        o_error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Apply one request to the register copy and build the result it gives
    task automatic apply_request(input t_op op, input logic [4:0] idx,
                                 input logic mmio, input logic [63:0] data,
                                 input logic [2:0] line, input logic level,
                                 output t_result res);
        logic [5:0]  off;
        logic [63:0] vec;
        logic [63:0] sbit;
        logic [4:0]  vreg;
        logic [4:0]  sreg;
        logic [2:0]  src;
        logic        active;
        logic        known;
        res  = '0;
        off  = {1'b0, idx} + (mmio ? 6'(MMIO_SHIFT) : 6'd0);
        vreg = REG_XV_FSP;
        sreg = REG_CR;
        sbit = '0;
        case (op)
            OP_READ: begin
                res.read_data = '1;
                res.status    = ST_UNIMP;
                case (off)
                    REG_FIR, REG_ACT0, REG_ACT1, REG_BAR, REG_FSPBAR, REG_CR,
                    REG_SEMR, REG_DMA, REG_STAT, REG_IRSN, REG_XV_FSP, REG_XV_OCC,
                    REG_XV_FSI, REG_XV_LPC, REG_XV_LOC, REG_XV_EXT: begin
                        res.read_data = bridge_regs[off[4:0]];
                        res.status    = ST_OK;
                    end
                    default: ;
                endcase
            end
            OP_WRITE: begin
                case (off)
                    REG_FIR, REG_ACT0, REG_ACT1, REG_SEMR, REG_DMA, REG_CR:
                        bridge_regs[off[4:0]] = data;
                    REG_FIR_OR:
                        bridge_regs[REG_FIR] = bridge_regs[REG_FIR] | data;
                    REG_FIR_AND:
                        bridge_regs[REG_FIR] = bridge_regs[REG_FIR] & data;
                    REG_BAR: begin
                        // BAR only takes writes from the scan path
                        if (mmio)
                            res.status = ST_REFUSED;
                        else
                            bridge_regs[REG_BAR] = data & BAR_WRITABLE;
                    end
                    REG_FSPBAR:
                        bridge_regs[REG_FSPBAR] = data & FSPBAR_WRITABLE;
                    REG_SCR:
                        bridge_regs[REG_CR] = bridge_regs[REG_CR] | data;
                    REG_CCR:
                        bridge_regs[REG_CR] = bridge_regs[REG_CR] & ~data;
                    REG_STAT:
                        res.status = ST_REFUSED;
                    REG_IRSN: begin
                        bridge_regs[REG_IRSN] = data & IRSN_WRITABLE;
                        res.offset_valid  = 1'b1;
                        res.source_offset = data[63:45];
                    end
                    REG_XV_FSP, REG_XV_OCC, REG_XV_FSI, REG_XV_LPC, REG_XV_LOC,
                    REG_XV_EXT: begin
                        // keep pending, take server, priority and source
                        vec = (bridge_regs[off[4:0]] & VEC_PENDING) | (data & VEC_FIELDS);
                        bridge_regs[off[4:0]] = vec;
                        if (vec[31:29] >= NUM_SOURCES) begin
                            res.status = ST_BAD_SRC;
                        end else begin
                            if (vec[39:32] == PRIO_MASKED)
                                bridge_regs[off[4:0]] = vec & ~VEC_PENDING;
                            res.route_valid    = 1'b1;
                            res.route_source   = vec[31:29];
                            res.route_server   = vec[55:42];
                            res.route_priority = vec[39:32];
                        end
                    end
                    default:
                        res.status = ST_UNIMP;
                endcase
            end
            OP_EVENT: begin
                known = 1'b1;
                case (line)
                    3'd0: begin vreg = REG_XV_FSP; sreg = REG_CR;   sbit = IRQ_PSI;    end
                    3'd1: begin vreg = REG_XV_FSP; sreg = REG_CR;   sbit = IRQ_FSP;    end
                    3'd2: begin vreg = REG_XV_OCC; sreg = REG_STAT; sbit = IRQ_OCC;    end
                    3'd3: begin vreg = REG_XV_FSI; sreg = REG_STAT; sbit = IRQ_FSI;    end
                    3'd4: begin vreg = REG_XV_LPC; sreg = REG_STAT; sbit = IRQ_LPC;    end
                    3'd5: begin vreg = REG_XV_LOC; sreg = REG_STAT; sbit = IRQ_LOCERR; end
                    3'd6: begin vreg = REG_XV_EXT; sreg = REG_STAT; sbit = IRQ_EXT;    end
                    default: known = 1'b0;
                endcase
                if (!known) begin
                    res.status = ST_BAD_SRC;
                end else begin
                    src    = bridge_regs[vreg][31:29];
                    active = level;
                    if (level) begin
                        bridge_regs[sreg] = bridge_regs[sreg] | sbit;
                        res.line_action   = ACT_RAISE;
                        res.line_source   = src;
                    end else begin
                        bridge_regs[sreg] = bridge_regs[sreg] & ~sbit;
                        // the shared PSI/FSP line stays up while the other is set
                        if (sreg != REG_CR ||
                            (bridge_regs[REG_CR] & (IRQ_PSI | IRQ_FSP)) == '0) begin
                            res.line_action = ACT_LOWER;
                            res.line_source = src;
                        end else begin
                            active = 1'b1;
                        end
                    end
                    if (active && (bridge_regs[vreg] & VEC_PRIO) != VEC_PRIO)
                        bridge_regs[vreg] = bridge_regs[vreg] | VEC_PENDING;
                    else
                        bridge_regs[vreg] = bridge_regs[vreg] & ~VEC_PENDING;
                end
            end
            default: ;
        endcase
    endtask

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin
        t_result observed;
        t_result predicted;
        t_result oldest;
        int      k;
        if (!i_rst_n) begin
            for (k = 0; k < NREGS; k++)
                bridge_regs[k] = '0;
            bridge_regs[REG_BAR]    = 64'h1;
            bridge_regs[REG_XV_FSP] = VEC_PRIO | {32'd0, 3'd0, 29'd0};
            bridge_regs[REG_XV_OCC] = VEC_PRIO | {32'd0, 3'd1, 29'd0};
            bridge_regs[REG_XV_FSI] = VEC_PRIO | {32'd0, 3'd2, 29'd0};
            bridge_regs[REG_XV_LPC] = VEC_PRIO | {32'd0, 3'd3, 29'd0};
            bridge_regs[REG_XV_LOC] = VEC_PRIO | {32'd0, 3'd4, 29'd0};
            bridge_regs[REG_XV_EXT] = VEC_PRIO | {32'd0, 3'd5, 29'd0};
            expected_results.delete();
            o_outstanding = 0;
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                observed.read_data      = i_read_data;
                observed.status         = t_status'(i_status);
                observed.line_action    = t_act'(i_line_action);
                observed.line_source    = i_line_source;
                observed.route_valid    = i_route_valid;
                observed.route_source   = i_route_source;
                observed.route_server   = i_route_server;
                observed.route_priority = i_route_priority;
                observed.offset_valid   = i_offset_valid;
                observed.source_offset  = i_source_offset;
                if (expected_results.size() == 0) begin
                    report_error("result returned with no request outstanding");
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("read_data", observed.read_data, oldest.read_data);
                    check_field("status", 64'(observed.status), 64'(oldest.status));
                    check_field("line_action", 64'(observed.line_action),
                                64'(oldest.line_action));
                    check_field("line_source", 64'(observed.line_source),
                                64'(oldest.line_source));
                    check_field("route_valid", 64'(observed.route_valid),
                                64'(oldest.route_valid));
                    check_field("route_source", 64'(observed.route_source),
                                64'(oldest.route_source));
                    check_field("route_server", 64'(observed.route_server),
                                64'(oldest.route_server));
                    check_field("route_priority", 64'(observed.route_priority),
                                64'(oldest.route_priority));
                    check_field("offset_valid", 64'(observed.offset_valid),
                                64'(oldest.offset_valid));
                    check_field("source_offset", 64'(observed.source_offset),
                                64'(oldest.source_offset));
                end
            end
            if (i_req_valid && !i_req_stall) begin
                apply_request(t_op'(i_operation), i_word_index, i_via_mmio, i_write_data,
                              i_line_number, i_line_level, predicted);
                expected_results.push_back(predicted);
            end
            o_outstanding = expected_results.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the service bridge register block: a directed pass
// over the aliases, refused and unimplemented accesses, vector routing and
// the shared interrupt line, then weighted random traffic with random gaps
// and result stalls. The checker beside the block reports the errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import sbirq_pkg::*;

    localparam int         RANDOM_ITEMS = 400;
    localparam logic [5:0] OFF_UNIMP    = 6'd3;
    localparam logic [5:0] OFF_BEYOND   = 6'd41;
    localparam logic [2:0] LINE_PSI     = 3'd0;
    localparam logic [2:0] LINE_FSP     = 3'd1;
    localparam logic [2:0] LINE_OCC     = 3'd2;
    localparam logic [2:0] LINE_BAD     = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [1:0]  i_operation   = OP_NONE;
    logic [4:0]  i_word_index  = '0;
    logic        i_via_mmio    = 1'b0;
    logic [63:0] i_write_data  = '0;
    logic [2:0]  i_line_number = '0;
    logic        i_line_level  = 1'b0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [63:0] o_read_data;
    logic [1:0]  o_status;
    logic [1:0]  o_line_action;
    logic [2:0]  o_line_source;
    logic        o_route_valid;
    logic [2:0]  o_route_source;
    logic [13:0] o_route_server;
    logic [7:0]  o_route_priority;
    logic        o_offset_valid;
    logic [18:0] o_source_offset;

    int          error_count;
    int          outstanding;
    logic        calm = 1'b0;

    // Offsets worth hitting often in the random part
    logic [4:0] hot_regs [0:19] = '{
        REG_FIR, REG_FIR_AND, REG_FIR_OR, REG_ACT0, REG_ACT1, REG_BAR, REG_FSPBAR,
        REG_CR, REG_SEMR, REG_XV_FSP, REG_SCR, REG_CCR, REG_DMA, REG_STAT,
        REG_XV_OCC, REG_XV_FSI, REG_XV_LPC, REG_XV_LOC, REG_XV_EXT, REG_IRSN
    };

    service_bridge_irq_register_block u_top (.*);

    sbirq_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_operation      (i_operation),
        .i_word_index     (i_word_index),
        .i_via_mmio       (i_via_mmio),
        .i_write_data     (i_write_data),
        .i_line_number    (i_line_number),
        .i_line_level     (i_line_level),
        .i_rsp_valid      (o_valid),
        .i_rsp_stall      (i_stall),
        .i_read_data      (o_read_data),
        .i_status         (o_status),
        .i_line_action    (o_line_action),
        .i_line_source    (o_line_source),
        .i_route_valid    (o_route_valid),
        .i_route_source   (o_route_source),
        .i_route_server   (o_route_server),
        .i_route_priority (o_route_priority),
        .i_offset_valid   (o_offset_valid),
        .i_source_offset  (o_source_offset),
        .o_error_count    (error_count),
        .o_outstanding    (outstanding)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stall the result side at random outside the calm stretch
    always @(negedge i_clk)
        i_stall <= !calm && ($urandom_range(99) < 13);

    // Present one request and hold it until accepted; entered at a falling edge
    task automatic send_request(input t_op op, input logic [4:0] idx, input logic mmio,
                                input logic [63:0] data, input logic [2:0] line,
                                input logic level);
        int gap;
        gap = (!calm && $urandom_range(99) < 13) ? 1 : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_word_index  <= idx;
        i_via_mmio    <= mmio;
        i_write_data  <= data;
        i_line_number <= line;
        i_line_level  <= level;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Register access by word offset on either path
    task automatic access_reg(input t_op op, input logic [5:0] off, input logic mmio,
                              input logic [63:0] data);
        send_request(op, mmio ? 5'(off - MMIO_SHIFT) : off[4:0], mmio, data, '0, 1'b0);
    endtask

    // Hold off the sender until every outstanding request has its result
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        int          n;
        int          pick;
        logic [4:0]  idx;
        logic        mmio;
        logic [5:0]  off;
        logic [63:0] data;
        logic [2:0]  line;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reads: reset BAR, unimplemented, beyond the file
        access_reg(OP_READ, REG_BAR, 1'b0, '0);
        access_reg(OP_READ, OFF_UNIMP, 1'b0, '0);
        access_reg(OP_READ, OFF_BEYOND, 1'b1, '0);
        // FIR and its AND/OR aliases
        access_reg(OP_WRITE, REG_FIR, 1'b0, '1);
        access_reg(OP_WRITE, REG_FIR_AND, 1'b0, 64'h00ff_00ff_00ff_00fe);
        access_reg(OP_WRITE, REG_FIR_OR, 1'b0, 64'h8000_0000_0000_0001);
        access_reg(OP_READ, REG_FIR, 1'b0, '0);
        // BAR refused from the memory-mapped path, masked from the scan path
        access_reg(OP_WRITE, REG_BAR, 1'b1, '1);
        access_reg(OP_WRITE, REG_BAR, 1'b0, '1);
        access_reg(OP_READ, REG_BAR, 1'b1, '0);
        access_reg(OP_WRITE, REG_FSPBAR, 1'b1, '1);
        // Read-only status, unimplemented and out-of-range writes, then an IRSN write
        access_reg(OP_WRITE, REG_STAT, 1'b0, '1);
        access_reg(OP_WRITE, OFF_UNIMP, 1'b0, '1);
        access_reg(OP_WRITE, OFF_BEYOND, 1'b1, '1);
        access_reg(OP_WRITE, REG_IRSN, 1'b1, '1);
        // Vectors: bad source, then routable ones
        access_reg(OP_WRITE, REG_XV_FSP, 1'b0, {8'hff, 16'h1234, 8'h10, 3'd6, 29'h1fff_ffff});
        access_reg(OP_WRITE, REG_XV_FSP, 1'b1, {8'h00, 16'h8000, 8'h05, 3'd0, 29'd0});
        access_reg(OP_WRITE, REG_XV_OCC, 1'b0, {8'h00, 16'hffff, 8'h00, 3'd1, 29'd0});
        // Pending set by an event, cleared by masking the vector
        send_request(OP_EVENT, '0, 1'b0, '0, LINE_OCC, 1'b1);
        access_reg(OP_READ, REG_XV_OCC, 1'b0, '0);
        access_reg(OP_WRITE, REG_XV_OCC, 1'b1, {8'h00, 16'h0004, 8'hff, 3'd1, 29'd0});
        access_reg(OP_READ, REG_XV_OCC, 1'b1, '0);
        // Shared PSI/FSP line: first deassert keeps it up, second lowers it
        send_request(OP_EVENT, '0, 1'b0, '0, LINE_PSI, 1'b1);
        send_request(OP_EVENT, '0, 1'b0, '0, LINE_FSP, 1'b1);
        send_request(OP_EVENT, '0, 1'b0, '0, LINE_PSI, 1'b0);
        send_request(OP_EVENT, '0, 1'b0, '0, LINE_FSP, 1'b0);
        send_request(OP_EVENT, '0, 1'b0, '0, LINE_BAD, 1'b1);
        send_request(OP_NONE, '1, 1'b1, '1, '1, 1'b1);
        // Control set/clear aliases
        access_reg(OP_WRITE, REG_SCR, 1'b1, '1);
        access_reg(OP_WRITE, REG_CCR, 1'b1, 64'h5555_aaaa_0f0f_f0f0);
        access_reg(OP_READ, REG_CR, 1'b1, '0);
        access_reg(OP_READ, REG_STAT, 1'b0, '0);
        wait_for_results();

        // Weighted random traffic
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 150 && n < 250);
            if (n == 100 || n == 300)
                wait_for_results();
            if ($urandom_range(1)) begin
                idx  = 5'($urandom_range(31));
                mmio = 1'($urandom_range(1));
            end else begin
                off  = {1'b0, hot_regs[$urandom_range(19)]};
                mmio = (off >= MMIO_SHIFT) && ($urandom_range(1) != 0);
                idx  = mmio ? 5'(off - MMIO_SHIFT) : off[4:0];
            end
            off  = {1'b0, idx} + (mmio ? 6'(MMIO_SHIFT) : 6'd0);
            data = {$urandom, $urandom};
            // vectors mostly get a routable source, sometimes a masked priority
            if (off == REG_XV_FSP || (off >= REG_XV_OCC && off <= REG_XV_EXT)) begin
                data[31:29] = ($urandom_range(7) != 0) ? 3'($urandom_range(5))
                                                       : 3'($urandom_range(7, 6));
                if ($urandom_range(3) == 0)
                    data[39:32] = PRIO_MASKED;
            end
            line = ($urandom_range(15) == 0) ? LINE_BAD : 3'($urandom_range(6));
            pick = $urandom_range(99);
            if (pick < 25)
                send_request(OP_READ, idx, mmio, data, line, 1'($urandom_range(1)));
            else if (pick < 60)
                send_request(OP_WRITE, idx, mmio, data, line, 1'($urandom_range(1)));
            else if (pick < 95)
                send_request(OP_EVENT, idx, mmio, data, line, 1'($urandom_range(1)));
            else
                send_request(OP_NONE, idx, mmio, data, line, 1'($urandom_range(1)));
        end
        calm = 1'b0;

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard: stop a run that hangs and report it as failed
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/sbirq_pkg.sv
hw/rtl/sbirq_decode.sv
hw/rtl/sbirq_store.sv
hw/rtl/sbirq_update.sv
hw/rtl/service_bridge_irq_register_block.sv
tb/sbirq_checker.sv
tb/tb_top.sv
